// ----- hw/rtl/diamond_square_terrain_assert.svh -----
// Assertion macros shared by the diamond-square terrain RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef DIAMOND_SQUARE_TERRAIN_ASSERT_SVH
`define DIAMOND_SQUARE_TERRAIN_ASSERT_SVH

// same-cycle implication
`define DST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/dst_pkg.sv -----
// Package for the diamond-square terrain block: widths, codes, shared types.
// No dependencies.
`default_nettype none
package dst_pkg;

	localparam int MAX_LEVELS_DEF = 5;
	localparam int NOISE_W  = 16;
	localparam int HEIGHT_W = 32;
	localparam int DECAY_W  = 17;
	localparam int LEVELS_W = 3;
	localparam int POS_W    = 6;
	localparam int AMP_W    = 22;
	localparam int IDX_W    = 2;
	localparam int FIFO_DEPTH = 4;

	localparam logic [DECAY_W-1:0] DECAY_ONE = 17'h10000;

	localparam logic [IDX_W-1:0] CFG_LEVELS = 2'd0;
	localparam logic [IDX_W-1:0] CFG_DECAY  = 2'd1;
	localparam logic [IDX_W-1:0] CFG_RC     = 2'd2;

	typedef struct packed {
		logic [LEVELS_W-1:0] levels;
		logic [DECAY_W-1:0]  decay;
		logic                rc;
	} cfg_t;

	typedef enum logic [1:0] {PH_CORNER, PH_DIAMOND, PH_SQUARE} phase_t;
	typedef enum logic {FR_RUN, FR_ZERO} front_st_t;
	typedef enum logic [2:0] {BK_IDLE, BK_READ, BK_TAIL, BK_DIV, BK_FIN} back_st_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dst_fifo.sv -----
// Small command queue between the sequencer and the point engine.
// Uses no package items.
`default_nettype none
module dst_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] data_in,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] data_out,
	output logic         empty
);
	localparam int PW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign full     = (cnt_q == (PW+1)'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign data_out = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= data_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/dst_front.sv -----
// Sequencer: accepts noise items, walks corners/diamond/square order, issues point commands.
// Depends on dst_pkg and diamond_square_terrain_assert.svh.
`default_nettype none
`include "diamond_square_terrain_assert.svh"
module dst_front #(
	parameter int MAX_LEVELS = dst_pkg::MAX_LEVELS_DEF,
	localparam int SIDE  = (1 << MAX_LEVELS) + 1,
	localparam int AWD   = $clog2(SIDE * SIDE),
	localparam int CMD_W = 5 * AWD + 2 * dst_pkg::POS_W + 4 + dst_pkg::NOISE_W
		+ dst_pkg::AMP_W + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dst_pkg::cfg_t                cfg,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [dst_pkg::NOISE_W-1:0]  noise,
	output logic                         cmd_push,
	output logic [CMD_W-1:0]             cmd_data,
	input  logic                         cmd_full
);
	localparam int CW = MAX_LEVELS + 2;
	localparam int LW = $clog2(MAX_LEVELS + 1);
	localparam logic [2:0] ZC_DIAMOND = 3'd4;
	localparam logic [2:0] ZC_LASTCORNER = 3'd3;
	localparam logic [1:0] CI_LAST = 2'd3;

	typedef struct packed {
		logic [AWD-1:0]               out_addr;
		logic [3:0][AWD-1:0]          nbr_addr;
		logic [3:0]                   nbr_en;
		logic [dst_pkg::POS_W-1:0]    row;
		logic [dst_pkg::POS_W-1:0]    col;
		logic [dst_pkg::NOISE_W-1:0]  noise;
		logic [dst_pkg::AMP_W-1:0]    amp;
		logic                         last;
	} cmd_t;

	function automatic logic [AWD-1:0] addr_of(logic [CW-1:0] r, logic [CW-1:0] c);
		addr_of = AWD'(32'(r) * SIDE + 32'(c));
	endfunction

	function automatic cmd_t corner_cmd(logic [1:0] k, logic [CW-1:0] s,
		logic [dst_pkg::NOISE_W-1:0] nz, logic [dst_pkg::AMP_W-1:0] a);
		cmd_t x;
		logic [CW-1:0] r, c;
		x = '0;
		r = (k == 2'd2 || k == 2'd3) ? s : '0;
		c = (k == 2'd1 || k == 2'd2) ? s : '0;
		x.out_addr = addr_of(r, c);
		x.row = dst_pkg::POS_W'(r);
		x.col = dst_pkg::POS_W'(c);
		x.noise = nz;
		x.amp = a;
		corner_cmd = x;
	endfunction

	dst_pkg::front_st_t fst_q, fst_d;
	dst_pkg::phase_t phase_q, nxt_phase;
	logic [1:0] cidx_q;
	logic [2:0] zc_q;
	logic [dst_pkg::NOISE_W-1:0] noise_hold_q;
	logic [CW-1:0] row_q, col_q, step_q, nxt_row, nxt_col, nxt_step;
	logic [LW-1:0] lvl_q, nxt_lvl, lat_lv_q, lv_live, eff_lv;
	logic [dst_pkg::DECAY_W-1:0] lat_dec_q, dpow_q, nxt_dpow, dec_live, eff_dec;
	logic lat_rc_q;
	logic [2*dst_pkg::DECAY_W-1:0] dp_prod;
	logic [CW-1:0] side_s, hh;
	logic grid_start, zero_start, accept, lvl_last, start_lv;
	logic [dst_pkg::NOISE_W-1:0] noise_sel;
	cmd_t cmd, lcmd;

	// live config, clamped; used at the first item of a grid
	always_comb begin
		if (cfg.levels == '0) lv_live = LW'(1);
		else if (32'(cfg.levels) > MAX_LEVELS) lv_live = LW'(MAX_LEVELS);
		else lv_live = LW'(cfg.levels);
		dec_live = (cfg.decay > dst_pkg::DECAY_ONE) ? dst_pkg::DECAY_ONE : cfg.decay;
		grid_start = (fst_q == dst_pkg::FR_RUN) && (phase_q == dst_pkg::PH_CORNER)
			&& (cidx_q == '0);
		eff_lv  = grid_start ? lv_live : lat_lv_q;
		eff_dec = grid_start ? dec_live : lat_dec_q;
		side_s  = CW'(1) << eff_lv;
		hh      = step_q >> 1;
	end

	assign zero_start = (fst_q == dst_pkg::FR_RUN) && grid_start && !cfg.rc;
	assign item_ready = (fst_q == dst_pkg::FR_RUN) && !cmd_full;
	assign accept     = item_valid && item_ready;
	assign cmd_push   = (accept && !zero_start) || ((fst_q == dst_pkg::FR_ZERO) && !cmd_full);
	assign noise_sel  = (fst_q == dst_pkg::FR_ZERO) ? noise_hold_q : noise;

	// diamond / square point and where the walk goes next
	always_comb begin
		lcmd = '0;
		nxt_row = row_q;
		nxt_col = col_q + step_q;
		nxt_step = step_q;
		nxt_phase = phase_q;
		lvl_last = 1'b0;
		start_lv = 1'b0;
		lcmd.noise = noise_sel;
		lcmd.amp = dst_pkg::AMP_W'(35 * 32'(dpow_q));
		if (phase_q == dst_pkg::PH_DIAMOND) begin
			lcmd.out_addr = addr_of(row_q + hh, col_q + hh);
			lcmd.row = dst_pkg::POS_W'(row_q + hh);
			lcmd.col = dst_pkg::POS_W'(col_q + hh);
			lcmd.nbr_en = 4'b1111;
			lcmd.nbr_addr[0] = addr_of(row_q, col_q);
			lcmd.nbr_addr[1] = addr_of(row_q + step_q, col_q);
			lcmd.nbr_addr[2] = addr_of(row_q + step_q, col_q + step_q);
			lcmd.nbr_addr[3] = addr_of(row_q, col_q + step_q);
			if (nxt_col >= side_s) begin
				nxt_col = '0;
				nxt_row = row_q + step_q;
				if (nxt_row >= side_s) begin
					nxt_phase = dst_pkg::PH_SQUARE;
					nxt_row = '0;
					nxt_col = hh;
				end
			end
		end else begin
			lcmd.out_addr = addr_of(row_q, col_q);
			lcmd.row = dst_pkg::POS_W'(row_q);
			lcmd.col = dst_pkg::POS_W'(col_q);
			lcmd.nbr_en[0] = (row_q >= hh);
			lcmd.nbr_en[1] = (row_q + hh <= side_s);
			lcmd.nbr_en[2] = (col_q >= hh);
			lcmd.nbr_en[3] = (col_q + hh <= side_s);
			lcmd.nbr_addr[0] = lcmd.nbr_en[0] ? addr_of(row_q - hh, col_q) : '0;
			lcmd.nbr_addr[1] = lcmd.nbr_en[1] ? addr_of(row_q + hh, col_q) : '0;
			lcmd.nbr_addr[2] = lcmd.nbr_en[2] ? addr_of(row_q, col_q - hh) : '0;
			lcmd.nbr_addr[3] = lcmd.nbr_en[3] ? addr_of(row_q, col_q + hh) : '0;
			if (nxt_col > side_s) begin
				nxt_row = row_q + hh;
				if (nxt_row > side_s) begin
					if (lvl_q >= lat_lv_q) begin
						lvl_last = 1'b1;
						nxt_phase = dst_pkg::PH_CORNER;
						nxt_row = '0;
						nxt_col = '0;
					end else begin
						nxt_step = hh;
						start_lv = 1'b1;
					end
				end else begin
					nxt_col = (nxt_row + hh) & (step_q - 1'b1);
				end
			end
			lcmd.last = lvl_last;
		end
		dp_prod = (2*dst_pkg::DECAY_W)'(dpow_q) * (2*dst_pkg::DECAY_W)'(lat_dec_q);
		nxt_dpow = dst_pkg::DECAY_W'((dp_prod + (2*dst_pkg::DECAY_W)'(32768)) >> 16);
		nxt_lvl = lvl_q + 1'b1;
		if (start_lv) begin
			nxt_phase = dst_pkg::PH_DIAMOND;
			nxt_row = '0;
			nxt_col = '0;
		end
	end

	always_comb begin
		if (fst_q == dst_pkg::FR_ZERO && zc_q != ZC_DIAMOND)
			cmd = corner_cmd(zc_q[1:0], side_s, '0, '0);
		else if (phase_q == dst_pkg::PH_CORNER)
			cmd = corner_cmd(cidx_q, side_s, noise_sel,
				dst_pkg::AMP_W'(15 * 32'(eff_dec)));
		else
			cmd = lcmd;
	end
	assign cmd_data = cmd;

	always_comb begin
		fst_d = fst_q;
		unique case (fst_q)
			dst_pkg::FR_RUN:  if (accept && zero_start) fst_d = dst_pkg::FR_ZERO;
			dst_pkg::FR_ZERO: if (!cmd_full && zc_q == ZC_DIAMOND) fst_d = dst_pkg::FR_RUN;
			default: fst_d = dst_pkg::FR_RUN;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && zero_start) noise_hold_q <= noise;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= dst_pkg::FR_RUN;
			phase_q <= dst_pkg::PH_CORNER;
			cidx_q <= '0;
			zc_q <= '0;
			row_q <= '0;
			col_q <= '0;
			step_q <= CW'(1) << MAX_LEVELS;
			lvl_q <= '0;
			lat_lv_q <= LW'(MAX_LEVELS);
			lat_dec_q <= 17'd16384;
			lat_rc_q <= 1'b1;
			dpow_q <= dst_pkg::DECAY_ONE;
		end else begin
			fst_q <= fst_d;
			if (accept && grid_start) begin
				lat_lv_q <= lv_live;
				lat_dec_q <= dec_live;
				lat_rc_q <= cfg.rc;
				step_q <= CW'(1) << lv_live;
				dpow_q <= dst_pkg::DECAY_ONE;
				lvl_q <= '0;
			end
			if (accept && zero_start) zc_q <= '0;
			if (cmd_push) begin
				if (fst_q == dst_pkg::FR_ZERO && zc_q != ZC_DIAMOND) begin
					zc_q <= zc_q + 1'b1;
					if (zc_q == ZC_LASTCORNER) begin
						dpow_q <= lat_dec_q;
						lvl_q <= LW'(1);
						phase_q <= dst_pkg::PH_DIAMOND;
						row_q <= '0;
						col_q <= '0;
					end
				end else if (phase_q == dst_pkg::PH_CORNER) begin
					cidx_q <= cidx_q + 1'b1;
					if (cidx_q == CI_LAST) begin
						// first level decay power is decay itself
						dpow_q <= lat_dec_q;
						lvl_q <= LW'(1);
						phase_q <= dst_pkg::PH_DIAMOND;
						row_q <= '0;
						col_q <= '0;
					end
				end else begin
					phase_q <= nxt_phase;
					row_q <= nxt_row;
					col_q <= nxt_col;
					step_q <= nxt_step;
					if (lvl_last) cidx_q <= '0;
					if (start_lv) begin
						lvl_q <= nxt_lvl;
						dpow_q <= nxt_dpow;
					end
				end
			end
		end
	end

	`DST_ASSERT_IMP(a_zero_blocks_input, fst_q == dst_pkg::FR_ZERO, !item_ready,
		"input taken while zero corners are issued")
	`DST_ASSERT_IMP(a_push_not_full, cmd_push, !cmd_full, "command pushed into full queue")
	`DST_ASSERT_IMP(a_dpow_range, 1'b1, dpow_q <= dst_pkg::DECAY_ONE && lat_rc_q == lat_rc_q,
		"decay power above one")
endmodule
`default_nettype wire

// ----- hw/rtl/dst_back.sv -----
// Point engine: reads neighbours from the height grid, averages, displaces, saturates.
// Depends on dst_pkg and diamond_square_terrain_assert.svh; holds the grid memory.
`default_nettype none
`include "diamond_square_terrain_assert.svh"
module dst_back #(
	parameter int MAX_LEVELS = dst_pkg::MAX_LEVELS_DEF,
	localparam int SIDE  = (1 << MAX_LEVELS) + 1,
	localparam int DEPTH = SIDE * SIDE,
	localparam int AWD   = $clog2(DEPTH),
	localparam int CMD_W = 5 * AWD + 2 * dst_pkg::POS_W + 4 + dst_pkg::NOISE_W
		+ dst_pkg::AMP_W + 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_pop,
	input  logic [CMD_W-1:0]                   cmd_data,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic [dst_pkg::POS_W-1:0]          row,
	output logic [dst_pkg::POS_W-1:0]          col,
	output logic signed [dst_pkg::HEIGHT_W-1:0] height,
	output logic                               last
);
	localparam int SW = dst_pkg::HEIGHT_W + 2;
	localparam int PRW = dst_pkg::NOISE_W + dst_pkg::AMP_W + 1;
	localparam int DW = 24;
	localparam int DIV_W = 36;
	localparam int HALF = DIV_W / 2;
	localparam int DIV3_SH = 20;
	localparam logic [DIV_W-1:0] DIV_BIAS = 36'd25769803776; // 3 * 2^33
	localparam logic [DIV_W-1:0] Q_BIAS   = 36'd8589934592;  // 2^33
	localparam logic [HALF:0]    DIV3_M   = 19'd349526;      // ceil(2^20 / 3)
	localparam logic [16:0]      DIV3_HI  = 17'd87381;       // (2^18 - 1) / 3

	typedef struct packed {
		logic [AWD-1:0]               out_addr;
		logic [3:0][AWD-1:0]          nbr_addr;
		logic [3:0]                   nbr_en;
		logic [dst_pkg::POS_W-1:0]    row;
		logic [dst_pkg::POS_W-1:0]    col;
		logic [dst_pkg::NOISE_W-1:0]  noise;
		logic [dst_pkg::AMP_W-1:0]    amp;
		logic                         last;
	} cmd_t;

	logic signed [dst_pkg::HEIGHT_W-1:0] grid_mem [DEPTH];
	logic signed [dst_pkg::HEIGHT_W-1:0] rdata_q, wr_data;
	logic [AWD-1:0] rd_addr;
	logic wr_en, out_free;

	dst_pkg::back_st_t bst_q, bst_d;
	cmd_t cmd_q;
	logic [1:0] j_q;
	logic pv_q;
	logic signed [SW-1:0] sum_q, sum_fin, mean_q, mean_sel;
	logic signed [PRW-1:0] prod_q;
	logic [DIV_W-1:0] y_q, q3;
	logic [HALF:0] fold;
	logic [2*HALF+1:0] fprod;
	logic [2:0] ncnt;
	logic signed [DW-1:0] disp;
	logic signed [SW:0] hsum;
	logic res_valid_q, last_q;
	logic [dst_pkg::POS_W-1:0] row_q, col_q;
	logic signed [dst_pkg::HEIGHT_W-1:0] height_q;

	always_ff @(posedge clk) begin
		if (wr_en) grid_mem[cmd_q.out_addr] <= wr_data;
		rdata_q <= grid_mem[rd_addr];
	end

	always_comb begin
		rd_addr = cmd_q.nbr_addr[j_q];
		sum_fin = sum_q + (pv_q ? SW'(rdata_q) : SW'(0));
		ncnt = 3'($countones(cmd_q.nbr_en));
		unique case (ncnt)
			3'd4: mean_sel = (sum_fin + SW'(2)) >>> 2;
			3'd2: mean_sel = (sum_fin + SW'(1)) >>> 1;
			default: mean_sel = sum_fin;
		endcase
		// divide by three: 2^18 = 1 mod 3, so fold the upper half onto the lower
		fold = (HALF+1)'(y_q[DIV_W-1:HALF]) + (HALF+1)'(y_q[HALF-1:0]);
		fprod = (2*HALF+2)'(fold) * (2*HALF+2)'(DIV3_M);
		q3 = DIV_W'(y_q[DIV_W-1:HALF]) * DIV_W'(DIV3_HI)
			+ DIV_W'(fprod[2*HALF+1:DIV3_SH]);
		disp = DW'((prod_q + PRW'(16384)) >>> 15);
		hsum = (SW+1)'(mean_q) + (SW+1)'(disp);
		if (hsum > (SW+1)'(64'sd2147483647)) wr_data = 32'sh7fffffff;
		else if (hsum < -(SW+1)'(64'sd2147483648)) wr_data = 32'sh80000000;
		else wr_data = dst_pkg::HEIGHT_W'(hsum);
	end

	assign out_free = !res_valid_q || res_ready;

	always_comb begin
		bst_d = bst_q;
		unique case (bst_q)
			dst_pkg::BK_IDLE: if (cmd_valid) bst_d = dst_pkg::BK_READ;
			dst_pkg::BK_READ: if (j_q == 2'd3) bst_d = dst_pkg::BK_TAIL;
			dst_pkg::BK_TAIL: bst_d = (ncnt == 3'd3) ? dst_pkg::BK_DIV : dst_pkg::BK_FIN;
			dst_pkg::BK_DIV:  bst_d = dst_pkg::BK_FIN;
			dst_pkg::BK_FIN:  if (out_free) bst_d = dst_pkg::BK_IDLE;
			default: bst_d = dst_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = (bst_q == dst_pkg::BK_IDLE) && cmd_valid;
		wr_en   = (bst_q == dst_pkg::BK_FIN) && out_free;
	end

	always_ff @(posedge clk) begin
		unique case (bst_q)
			dst_pkg::BK_IDLE: begin
				cmd_q <= cmd_data;
				sum_q <= '0;
			end
			dst_pkg::BK_READ: begin
				if (pv_q) sum_q <= sum_fin;
				prod_q <= $signed(cmd_q.noise) * $signed({1'b0, cmd_q.amp});
			end
			dst_pkg::BK_TAIL: begin
				mean_q <= mean_sel;
				// floor((s+1)/3) on a biased, non-negative value
				y_q <= DIV_W'(sum_fin) + DIV_W'(1) + DIV_BIAS;
			end
			dst_pkg::BK_DIV: begin
				mean_q <= SW'(q3 - Q_BIAS);
			end
			dst_pkg::BK_FIN: begin
				if (out_free) begin
					row_q <= cmd_q.row;
					col_q <= cmd_q.col;
					height_q <= wr_data;
					last_q <= cmd_q.last;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q <= dst_pkg::BK_IDLE;
			j_q <= '0;
			pv_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			bst_q <= bst_d;
			if (bst_q == dst_pkg::BK_IDLE) begin
				j_q <= '0;
				pv_q <= 1'b0;
			end else if (bst_q == dst_pkg::BK_READ) begin
				j_q <= j_q + 1'b1;
				pv_q <= cmd_q.nbr_en[j_q];
			end
			if (wr_en) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign row = row_q;
	assign col = col_q;
	assign height = height_q;
	assign last = last_q;

	`DST_ASSERT_NXT(a_fin_loads_out, wr_en, res_valid_q, "finished point not presented")
	`DST_ASSERT_NXT(a_div_one_cycle, bst_q == dst_pkg::BK_DIV, bst_q == dst_pkg::BK_FIN,
		"divide step not followed by finish")
	`DST_ASSERT_IMP(a_pop_only_idle, cmd_pop, bst_q == dst_pkg::BK_IDLE && cmd_valid,
		"command popped while busy")
endmodule
`default_nettype wire

// ----- hw/rtl/diamond_square_terrain.sv -----
// Diamond-square terrain generator, one height point per noise item (5 on a zero-corner start).
// Point engine: one command at a time, with an extra divide step for three-neighbour points; its
// single grid read port, read four times per point, limits throughput. A 4-entry queue decouples input.
// Reset: asynchronous, clears sequencing and config (levels 5, decay 0.25, random corners on);
// the grid memory is not cleared, each point is written before it is read.
`default_nettype none
module diamond_square_terrain #(
	parameter int MAX_LEVELS = dst_pkg::MAX_LEVELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dst_pkg::IDX_W-1:0]           cfg_index,
	input  logic [dst_pkg::DECAY_W-1:0]         cfg_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic signed [dst_pkg::NOISE_W-1:0]  noise,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [dst_pkg::POS_W-1:0]           row,
	output logic [dst_pkg::POS_W-1:0]           col,
	output logic signed [dst_pkg::HEIGHT_W-1:0] height,
	output logic                                last
);
	localparam int SIDE  = (1 << MAX_LEVELS) + 1;
	localparam int AWD   = $clog2(SIDE * SIDE);
	localparam int CMD_W = 5 * AWD + 2 * dst_pkg::POS_W + 4 + dst_pkg::NOISE_W
		+ dst_pkg::AMP_W + 1;

	dst_pkg::cfg_t cfg_q;
	logic cmd_push, cmd_full, cmd_pop, cmd_empty;
	logic [CMD_W-1:0] push_data, pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.levels <= 3'd5;
			cfg_q.decay  <= 17'd16384;
			cfg_q.rc     <= 1'b1;
		end else if (cfg_valid) begin
			priority case (cfg_index)
				dst_pkg::CFG_LEVELS: cfg_q.levels <= cfg_data[dst_pkg::LEVELS_W-1:0];
				dst_pkg::CFG_DECAY:  cfg_q.decay  <= cfg_data;
				dst_pkg::CFG_RC:     cfg_q.rc     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	dst_front #(.MAX_LEVELS(MAX_LEVELS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.item_valid(item_valid), .item_ready(item_ready), .noise(noise),
		.cmd_push(cmd_push), .cmd_data(push_data), .cmd_full(cmd_full)
	);

	dst_fifo #(.W(CMD_W), .DEPTH(dst_pkg::FIFO_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(cmd_push), .data_in(push_data), .full(cmd_full),
		.pop(cmd_pop), .data_out(pop_data), .empty(cmd_empty)
	);

	dst_back #(.MAX_LEVELS(MAX_LEVELS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(!cmd_empty), .cmd_pop(cmd_pop), .cmd_data(pop_data),
		.res_valid(res_valid), .res_ready(res_ready),
		.row(row), .col(col), .height(height), .last(last)
	);
endmodule
`default_nettype wire

// ----- bench/tb_diamond_square_terrain.sv -----
// Testbench for diamond_square_terrain: noise items in random order with random idling,
// a class-based grid predictor and a result checker. Depends on dst_pkg and the RTL.
`timescale 1ns / 100ps

typedef struct {
	int unsigned row;
	int unsigned col;
	int          height;
	bit          last;
} point_t;

class terrain_scoreboard;
	int          grid_h [33][33];
	int unsigned levels_reg, decay_reg, rc_reg;
	int unsigned lat_levels, lat_decay, lat_rc;
	int unsigned level_n, step, cur_r, cur_c, corner_k, decay_pow, amp;
	dst_pkg::phase_t ph;
	point_t      pending [$];
	int          errors;
	int          points;
	int          grids;
	bit          grid_done;

	function new();
		levels_reg = 5; decay_reg = 16384; rc_reg = 1;
		lat_levels = 5; lat_decay = 16384; lat_rc = 1;
		level_n = 0; step = 32; cur_r = 0; cur_c = 0; corner_k = 0;
		ph = dst_pkg::PH_CORNER; decay_pow = 65536; amp = 15 * 16384;
		errors = 0; points = 0; grids = 0; grid_done = 0;
		foreach (grid_h[i, j]) grid_h[i][j] = 0;
	endfunction

	function void write_cfg(logic [dst_pkg::IDX_W-1:0] idx, int unsigned v);
		case (idx)
			dst_pkg::CFG_LEVELS: levels_reg = v & 7;
			dst_pkg::CFG_DECAY:  decay_reg = v & 32'h1FFFF;
			dst_pkg::CFG_RC:     rc_reg = v & 1;
			default: ;
		endcase
	endfunction

	function bit at_grid_start();
		return (ph == dst_pkg::PH_CORNER) && (corner_k == 0);
	endfunction

	function longint fdiv(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) q--;
		return q;
	endfunction

	function int displaced(longint sum, longint cnt, int nz);
		longint h;
		h = fdiv(2 * sum + cnt, 2 * cnt) + fdiv(longint'(nz) * longint'(amp) + 16384, 32768);
		if (h > 64'sd2147483647) h = 64'sd2147483647;
		if (h < -64'sd2147483648) h = -64'sd2147483648;
		return int'(h);
	endfunction

	function void put(int unsigned r, int unsigned c, int v, bit lst);
		point_t p;
		grid_h[r][c] = v;
		p.row = r; p.col = c; p.height = v; p.last = lst;
		pending.insert(pending.size(), p);
		if (lst) begin
			grid_done = 1;
			grids++;
		end
	endfunction

	function void next_level(int unsigned n);
		level_n = n & 7;
		decay_pow = int'((longint'(decay_pow) * lat_decay + 32768) >> 16);
		amp = 35 * decay_pow;
		ph = dst_pkg::PH_DIAMOND;
		cur_r = 0; cur_c = 0;
	endfunction

	// accepted noise item: compute the points it writes
	function void note_item(logic signed [15:0] nz_in);
		int          nz;
		int unsigned s, h, r, c, k;
		longint      sum, cnt;
		bit          lst;
		nz = nz_in;
		if (ph == dst_pkg::PH_CORNER) begin
			if (corner_k == 0) begin
				lat_levels = levels_reg < 1 ? 1 : (levels_reg > 5 ? 5 : levels_reg);
				lat_decay = decay_reg > 65536 ? 65536 : decay_reg;
				lat_rc = rc_reg;
				step = 1 << lat_levels;
				decay_pow = 65536;
				amp = 15 * lat_decay;
				level_n = 0;
			end
			s = 1 << lat_levels;
			if (lat_rc) begin
				k = corner_k & 3;
				put((k >= 2) ? s : 0, (k == 1 || k == 2) ? s : 0, displaced(0, 1, nz), 0);
				corner_k = k + 1;
				if (corner_k == 4) begin
					corner_k = 0;
					next_level(1);
				end
				return;
			end
			put(0, 0, 0, 0); put(0, s, 0, 0); put(s, s, 0, 0); put(s, 0, 0, 0);
			corner_k = 0;
			next_level(1);
		end
		s = 1 << lat_levels;
		h = step >> 1;
		r = cur_r; c = cur_c;
		if (ph == dst_pkg::PH_DIAMOND) begin
			sum = longint'(grid_h[r][c]) + grid_h[r+step][c] + grid_h[r+step][c+step]
				+ grid_h[r][c+step];
			put(r + h, c + h, displaced(sum, 4, nz), 0);
			cur_c += step;
			if (cur_c >= s) begin
				cur_c = 0;
				cur_r += step;
				if (cur_r >= s) begin
					ph = dst_pkg::PH_SQUARE; cur_r = 0; cur_c = h;
				end
			end
			return;
		end
		sum = 0; cnt = 0; lst = 0;
		if (r >= h) begin sum += grid_h[r-h][c]; cnt++; end
		if (r + h <= s) begin sum += grid_h[r+h][c]; cnt++; end
		if (c >= h) begin sum += grid_h[r][c-h]; cnt++; end
		if (c + h <= s) begin sum += grid_h[r][c+h]; cnt++; end
		if (cnt == 0) cnt = 1;
		k = displaced(sum, cnt, nz);
		cur_c += step;
		if (cur_c > s) begin
			cur_r += h;
			if (cur_r > s) begin
				if (level_n >= lat_levels) begin
					lst = 1;
					ph = dst_pkg::PH_CORNER; corner_k = 0; cur_r = 0; cur_c = 0;
				end else begin
					step = h;
					next_level(level_n + 1);
				end
			end else begin
				cur_c = (cur_r + h) & (step - 1);
			end
		end
		put(r, c, int'(k), lst);
	endfunction

	function void check_point(logic [5:0] r, logic [5:0] c, logic signed [31:0] hgt, logic l);
		point_t p;
		if (pending.size() == 0) begin
			$error("unexpected point at row %0d col %0d", r, c);
			errors++;
			return;
		end
		p = pending.pop_front();
		points++;
		if (r !== p.row[5:0]) begin
			$error("row: expected %0d, got %0d", p.row, r); errors++;
		end
		if (c !== p.col[5:0]) begin
			$error("col: expected %0d, got %0d", p.col, c); errors++;
		end
		if (hgt !== p.height) begin
			$error("height: expected %0d, got %0d", p.height, hgt); errors++;
		end
		if (l !== p.last) begin
			$error("last: expected %0d, got %0d", p.last, l); errors++;
		end
	endfunction
endclass

module tb_diamond_square_terrain;
	localparam int WATCHDOG = 5000;
	localparam int SETTLE = 40;

	logic                        clk = 0;
	logic                        arst_n = 0;
	logic                        cfg_valid = 0;
	logic                        cfg_ready;
	logic [dst_pkg::IDX_W-1:0]   cfg_index = dst_pkg::CFG_LEVELS;
	logic [dst_pkg::DECAY_W-1:0] cfg_data = '0;
	logic                        item_valid = 0;
	logic                        item_ready;
	logic signed [15:0]          noise = '0;
	logic                        res_valid;
	logic                        res_ready = 0;
	logic [5:0]                  row, col;
	logic signed [31:0]          height;
	logic                        last;

	terrain_scoreboard sb = new();
	bit quiet = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int items_sent = 0;

	diamond_square_terrain uut (.*);

	always #5 clk = ~clk;

	// result side with random stalls
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			sb.check_point(row, col, height, last);
			stall_left = quiet ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14));
		end
		if (stall_left > 0) begin
			res_ready <= 0;
			stall_left--;
		end else
			res_ready <= arst_n;
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [dst_pkg::IDX_W-1:0] idx, int unsigned v);
		cfg_index <= idx;
		cfg_data <= v[dst_pkg::DECAY_W-1:0];
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.write_cfg(idx, v);
	endtask

	// valid is only dropped when a gap follows
	task automatic send_noise(logic signed [15:0] v);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			item_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1;
		noise <= v;
		do @(posedge clk); while (!item_ready);
		sb.note_item(v);
		items_sent++;
	endtask

	task automatic drain();
		item_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_noise();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic finish_grid();
		sb.grid_done = 0;
		while (!sb.grid_done) send_noise(rand_noise());
	endtask

	initial begin
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// zero corners, level count below range, unit decay
		write_reg(dst_pkg::CFG_LEVELS, 0);
		write_reg(dst_pkg::CFG_RC, 0);
		write_reg(dst_pkg::CFG_DECAY, 65536);
		send_noise(16'sh8000); send_noise(16'sh7FFF); send_noise(0);
		send_noise(16'sh0001); send_noise(16'shFFFF);
		drain();
		// random corners, zero decay
		write_reg(dst_pkg::CFG_RC, 1);
		write_reg(dst_pkg::CFG_DECAY, 0);
		finish_grid();
		drain();
		// decay above one, two levels
		write_reg(dst_pkg::CFG_DECAY, 131071);
		write_reg(dst_pkg::CFG_LEVELS, 2);
		quiet = 1;
		finish_grid();
		drain();
		quiet = 0;

		while (items_sent < 440) begin
			quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1))
				write_reg(dst_pkg::CFG_LEVELS, $urandom_range(0, 3));
			if ($urandom_range(0, 1))
				case ($urandom_range(0, 4))
					0: write_reg(dst_pkg::CFG_DECAY, 0);
					1: write_reg(dst_pkg::CFG_DECAY, 65536);
					2: write_reg(dst_pkg::CFG_DECAY, $urandom_range(65537, 131071));
					default: write_reg(dst_pkg::CFG_DECAY, $urandom_range(0, 65536));
				endcase
			if ($urandom_range(0, 1))
				write_reg(dst_pkg::CFG_RC, $urandom_range(0, 1));
			if ($urandom_range(0, 2) != 0)
				finish_grid();
			else begin
				n = $urandom_range(1, 40);
				repeat (n) send_noise(rand_noise());
			end
			drain();
		end

		// close the open grid, then the start of a largest-size grid, levels above range
		quiet = 0;
		if (!sb.at_grid_start()) finish_grid();
		drain();
		write_reg(dst_pkg::CFG_LEVELS, 7);
		write_reg(dst_pkg::CFG_RC, $urandom_range(0, 1));
		repeat (40) send_noise(rand_noise());
		drain();

		$display("Sent %0d noise items, checked %0d points over %0d complete grids.",
			items_sent, sb.points, sb.grids);
		$display("Mismatches: %0d, points still expected: %0d", sb.errors, sb.pending.size());
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/dst_pkg.sv
hw/rtl/dst_fifo.sv
hw/rtl/dst_front.sv
hw/rtl/dst_back.sv
hw/rtl/diamond_square_terrain.sv
bench/tb_diamond_square_terrain.sv
